// ===== sv/salsa20_stream_cipher_defines.svh =====
// Assertion macros used by the salsa20 sequencer.
`ifndef SALSA20_STREAM_CIPHER_DEFINES_SVH
`define SALSA20_STREAM_CIPHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define S20_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define S20_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S20_ASSERT(label, prop, msg)
`define S20_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/salsa20_pkg.sv =====
// Types, constants and codes shared by the salsa20 stream cipher modules.
package salsa20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY01 = 3'd0,
    CFG_KEY23 = 3'd1,
    CFG_KEY45 = 3'd2,
    CFG_KEY67 = 3'd3,
    CFG_NONCE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_message;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_words_0_1;
    logic [63:0] key_words_2_3;
    logic [63:0] key_words_4_5;
    logic [63:0] key_words_6_7;
    logic [63:0] message_nonce;
  } key_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_QSTEP,
    OP_ADD,
    OP_SHIFT
  } dp_op_t;

  typedef enum logic [2:0] {
    ROT_0,
    ROT_7,
    ROT_9,
    ROT_13,
    ROT_18
  } rot_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] qstep;
    logic       qr_last;
    logic [3:0] add_idx;
  } ctrl_t;

endpackage

// ===== sv/salsa20_stream_cipher.sv =====
// Salsa20 byte stream cipher. A byte inside a block goes from accept straight to the emit
// state, where its result is registered. The first byte of a 64-byte block first runs the
// DOUBLE_ROUNDS double rounds on one add-rotate-xor unit, one quarter-round line per cycle,
// then the sixteen words are added back before the byte goes to the emit state.
// One item is in flight; a result stalled at the output holds the next byte. Synchronous reset
// clears config registers, byte position, block counter and handshakes, not the keystream words.
module salsa20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = salsa20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  salsa20_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output salsa20_pkg::out_item_t              out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [salsa20_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                         cfg_data
);

  salsa20_pkg::key_cfg_t key;
  salsa20_pkg::in_item_t item;
  salsa20_pkg::ctrl_t    ctrl;
  logic [63:0]           blk_count;
  logic [7:0]            ks_byte;
  logic                  emit;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        salsa20_pkg::CFG_KEY01: key.key_words_0_1 <= cfg_data;
        salsa20_pkg::CFG_KEY23: key.key_words_2_3 <= cfg_data;
        salsa20_pkg::CFG_KEY45: key.key_words_4_5 <= cfg_data;
        salsa20_pkg::CFG_KEY67: key.key_words_6_7 <= cfg_data;
        salsa20_pkg::CFG_NONCE: key.message_nonce <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  salsa20_seq #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_last (item.last_of_message),
    .out_free  (out_free),
    .emit      (emit),
    .ctrl      (ctrl),
    .blk_count (blk_count)
  );

  salsa20_state u_state (
    .clk       (clk),
    .ctrl      (ctrl),
    .key       (key),
    .blk_count (blk_count),
    .ks_byte   (ks_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte       <= item.data_byte ^ ks_byte;
      out_data.end_of_message <= item.last_of_message;
    end
  end

endmodule

// ===== sv/salsa20_qr_unit.sv =====
// Shared add, rotate and XOR unit: res = x ^ rotl(y + z, n).
module salsa20_qr_unit (
  input  logic [31:0]       x,
  input  logic [31:0]       y,
  input  logic [31:0]       z,
  input  salsa20_pkg::rot_t rot,
  output logic [31:0]       res
);

  logic [31:0] sum;
  logic [31:0] rotd;

  always_comb begin
    sum = y + z;
    case (rot)
      salsa20_pkg::ROT_7:  rotd = {sum[24:0], sum[31:25]};
      salsa20_pkg::ROT_9:  rotd = {sum[22:0], sum[31:23]};
      salsa20_pkg::ROT_13: rotd = {sum[18:0], sum[31:19]};
      salsa20_pkg::ROT_18: rotd = {sum[13:0], sum[31:14]};
      salsa20_pkg::ROT_0:  rotd = sum;
      default:             rotd = sum;
    endcase
    res = x ^ rotd;
  end

endmodule

// ===== sv/salsa20_state.sv =====
// Sixteen-word working state with fixed permutations and the keystream shift line.
module salsa20_state (
  input  logic                  clk,
  input  salsa20_pkg::ctrl_t    ctrl,
  input  salsa20_pkg::key_cfg_t key,
  input  logic [63:0]           blk_count,
  output logic [7:0]            ks_byte
);

  logic [31:0] w        [16];
  logic [31:0] w_next   [16];
  logic [31:0] init     [16];
  logic [31:0] upd      [16];
  logic [31:0] perm_r5  [16];
  logic [31:0] perm_tr  [16];
  logic [31:0] shifted  [16];
  logic [31:0] rotated  [16];

  logic [31:0]       ux;
  logic [31:0]       uy;
  logic [31:0]       uz;
  logic [31:0]       ures;
  salsa20_pkg::rot_t urot;

  assign init[0]  = salsa20_pkg::SIGMA0;
  assign init[1]  = key.key_words_0_1[31:0];
  assign init[2]  = key.key_words_0_1[63:32];
  assign init[3]  = key.key_words_2_3[31:0];
  assign init[4]  = key.key_words_2_3[63:32];
  assign init[5]  = salsa20_pkg::SIGMA1;
  assign init[6]  = key.message_nonce[31:0];
  assign init[7]  = key.message_nonce[63:32];
  assign init[8]  = blk_count[31:0];
  assign init[9]  = blk_count[63:32];
  assign init[10] = salsa20_pkg::SIGMA2;
  assign init[11] = key.key_words_4_5[31:0];
  assign init[12] = key.key_words_4_5[63:32];
  assign init[13] = key.key_words_6_7[31:0];
  assign init[14] = key.key_words_6_7[63:32];
  assign init[15] = salsa20_pkg::SIGMA3;

  // The quarter round always works on words 0, 4, 8 and 12 (a, b, c, d).
  always_comb begin
    ux   = w[4];
    uy   = w[0];
    uz   = w[12];
    urot = salsa20_pkg::ROT_7;
    if (ctrl.op == salsa20_pkg::OP_ADD) begin
      ux   = '0;
      uy   = w[0];
      uz   = init[ctrl.add_idx];
      urot = salsa20_pkg::ROT_0;
    end else begin
      case (ctrl.qstep)
        2'd0: begin
          ux   = w[4];
          uy   = w[0];
          uz   = w[12];
          urot = salsa20_pkg::ROT_7;
        end
        2'd1: begin
          ux   = w[8];
          uy   = w[4];
          uz   = w[0];
          urot = salsa20_pkg::ROT_9;
        end
        2'd2: begin
          ux   = w[12];
          uy   = w[8];
          uz   = w[4];
          urot = salsa20_pkg::ROT_13;
        end
        default: begin
          ux   = w[0];
          uy   = w[12];
          uz   = w[8];
          urot = salsa20_pkg::ROT_18;
        end
      endcase
    end
  end

  salsa20_qr_unit u_qr (
    .x   (ux),
    .y   (uy),
    .z   (uz),
    .rot (urot),
    .res (ures)
  );

  always_comb begin
    upd = w;
    case (ctrl.qstep)
      2'd0:    upd[4]  = ures;
      2'd1:    upd[8]  = ures;
      2'd2:    upd[12] = ures;
      default: upd[0]  = ures;
    endcase
  end

  // Between quarter rounds rotate by five words so the next column lands on
  // 0/4/8/12; after the fourth, undo the drift and transpose, which switches the
  // next round between a column round and a row round.
  for (genvar g = 0; g < 16; g++) begin : g_wire
    localparam int R5 = (g + 5) % 16;
    localparam int TR = ((g % 4) * 4 + g / 4 + 1) % 16;
    localparam int NX = (g + 1) % 16;
    assign perm_r5[g] = upd[R5];
    assign perm_tr[g] = upd[TR];
    if (g == 15) begin : g_tail
      assign shifted[g] = {8'h00, w[g][31:8]};
      assign rotated[g] = ures;
    end else begin : g_body
      assign shifted[g] = {w[NX][7:0], w[g][31:8]};
      assign rotated[g] = w[NX];
    end
  end

  always_comb begin
    w_next = w;
    case (ctrl.op)
      salsa20_pkg::OP_LOAD: w_next = init;
      salsa20_pkg::OP_QSTEP: begin
        if (ctrl.qstep != 2'd3) begin
          w_next = upd;
        end else if (ctrl.qr_last) begin
          w_next = perm_tr;
        end else begin
          w_next = perm_r5;
        end
      end
      salsa20_pkg::OP_ADD:   w_next = rotated;
      salsa20_pkg::OP_SHIFT: w_next = shifted;
      default:               w_next = w;
    endcase
  end

  always_ff @(posedge clk) begin
    w <= w_next;
  end

  assign ks_byte = w[0][7:0];

endmodule

// ===== sv/salsa20_seq.sv =====
// Sequencer: round and add-back counters, byte position and block counter.
`include "salsa20_stream_cipher_defines.svh"
module salsa20_seq #(
  parameter int DOUBLE_ROUNDS = salsa20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               item_last,
  input  logic               out_free,
  output logic               emit,
  output salsa20_pkg::ctrl_t ctrl,
  output logic [63:0]        blk_count
);

  localparam int ROUND_STEPS = DOUBLE_ROUNDS * 32;
  localparam int CNT_W       = $clog2(ROUND_STEPS);

  salsa20_pkg::seq_state_t state;
  salsa20_pkg::seq_state_t state_next;
  logic [CNT_W-1:0]        cnt;
  logic [3:0]              add_idx;
  logic [5:0]              pos;
  logic                    round_done;

  assign round_done = (cnt == CNT_W'(ROUND_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      salsa20_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (pos == '0) ? salsa20_pkg::ST_ROUND : salsa20_pkg::ST_EMIT;
        end
      end
      salsa20_pkg::ST_ROUND: begin
        if (round_done) begin
          state_next = salsa20_pkg::ST_ADD;
        end
      end
      salsa20_pkg::ST_ADD: begin
        if (&add_idx) begin
          state_next = salsa20_pkg::ST_EMIT;
        end
      end
      salsa20_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = salsa20_pkg::ST_IDLE;
        end
      end
      default: state_next = salsa20_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    emit         = 1'b0;
    ctrl.op      = salsa20_pkg::OP_HOLD;
    ctrl.qstep   = cnt[1:0];
    ctrl.qr_last = &cnt[3:2];
    ctrl.add_idx = add_idx;
    case (state)
      salsa20_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && pos == '0) begin
          ctrl.op = salsa20_pkg::OP_LOAD;
        end
      end
      salsa20_pkg::ST_ROUND: ctrl.op = salsa20_pkg::OP_QSTEP;
      salsa20_pkg::ST_ADD:   ctrl.op = salsa20_pkg::OP_ADD;
      salsa20_pkg::ST_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          ctrl.op = salsa20_pkg::OP_SHIFT;
        end
      end
      default: ctrl.op = salsa20_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= salsa20_pkg::ST_IDLE;
      cnt       <= '0;
      add_idx   <= '0;
      pos       <= '0;
      blk_count <= '0;
    end else begin
      state <= state_next;
      if (ctrl.op == salsa20_pkg::OP_LOAD) begin
        cnt     <= '0;
        add_idx <= '0;
      end else begin
        if (state == salsa20_pkg::ST_ROUND) begin
          cnt <= cnt + 1'b1;
        end
        if (state == salsa20_pkg::ST_ADD) begin
          add_idx <= add_idx + 1'b1;
        end
      end
      if (emit) begin
        if (item_last) begin
          pos       <= '0;
          blk_count <= '0;
        end else begin
          pos <= pos + 1'b1;
          // advance the block index as the position wraps
          if (&pos) begin
            blk_count <= blk_count + 64'd1;
          end
        end
      end
    end
  end

  `S20_ASSERT(a_mid_block_direct, (in_valid && in_ready && pos != '0) |=> (state == salsa20_pkg::ST_EMIT), "byte inside a block must go straight to emit")
  `S20_ASSERT(a_add_to_emit, (state == salsa20_pkg::ST_ADD && add_idx == 4'd15) |=> (state == salsa20_pkg::ST_EMIT), "add-back must end after sixteen words")
  `S20_ASSERT(a_pos_on_emit, !emit |=> $stable(pos), "byte position moved without an emitted item")
  `S20_ASSERT(a_blk_on_emit, !emit |=> $stable(blk_count), "block counter moved without an emitted item")
  `S20_ASSERT_ALWAYS(a_rst_clears, rst |=> (state == salsa20_pkg::ST_IDLE && pos == '0), "reset must return to idle at position zero")

endmodule
